// File: sv/pfc_pkg.sv
package pfc_pkg;

  localparam int ByteW = 8;
  localparam int SeqW = 6;
  localparam int CrcW = 16;
  localparam int SlotW = 3;

  localparam logic [ByteW-1:0] MaxData = 8'd250;
  localparam logic [ByteW-1:0] LenOverhead = 8'd5;
  localparam logic [CrcW-1:0] CrcPoly = 16'h1021;
  localparam logic [ByteW-1:0] StartMarkReset = 8'h01;
  localparam logic [ByteW-1:0] EndCharReset = 8'h0D;

  localparam logic ModeHeader = 1'b0;
  localparam logic ModeData = 1'b1;

  typedef enum logic [0:0] {
    CFG_START_MARK = 1'b0,
    CFG_END_CHAR   = 1'b1
  } cfg_idx_t;

  // closing slots that follow the literal bytes of a group
  localparam logic [SlotW-1:0] SlotCrcLo = 3'd0;
  localparam logic [SlotW-1:0] SlotCrcHi = 3'd1;
  localparam logic [SlotW-1:0] SlotEnd = 3'd2;

  // one item's worth of output bytes: up to four literals plus an optional close
  typedef struct packed {
    logic [3:0][ByteW-1:0] lit;
    logic [SlotW-1:0]      nlit;
    logic                  restart;
    logic                  close_pkt;
  } grp_t;

  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                               input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[CrcW-1] ? ({c[CrcW-2:0], 1'b0} ^ CrcPoly) : {c[CrcW-2:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// File: sv/pfc_in_if.sv
interface pfc_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [pfc_pkg::ByteW-1:0]   packet_type;
  logic [pfc_pkg::SeqW-1:0]    seq_num;
  logic [pfc_pkg::ByteW-1:0]   data_len;
  logic [pfc_pkg::ByteW-1:0]   data_byte;

  modport source(output valid, mode, packet_type, seq_num, data_len, data_byte,
                 input ready);
  modport sink(input valid, mode, packet_type, seq_num, data_len, data_byte,
               output ready);
endinterface

// File: sv/pfc_out_if.sv
interface pfc_out_if;
  logic                      valid;
  logic                      ready;
  logic [pfc_pkg::ByteW-1:0] out_byte;
  logic                      end_of_packet;

  modport source(output valid, out_byte, end_of_packet, input ready);
  modport sink(input valid, out_byte, end_of_packet, output ready);
endinterface

// File: sv/pfc_cfg_if.sv
interface pfc_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [0:0]                index;
  logic [pfc_pkg::ByteW-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: sv/packet_framer_crc16.sv
// an item is held in pfc_ctrl's input stage, then in pfc_emit's cur register
// throughput: one output byte per cycle while out_ch.ready is high; a data
// byte gives one byte, the last data byte four, a header four, or seven for an
// empty packet (output port bound); crc takes in each literal byte as it leaves
// reset clears all valid flags, packet state and crc, and sets start_mark to
// 0x01 and end_char to 0x0D
module packet_framer_crc16 (
  input  logic      clk,
  input  logic      rst,
  pfc_in_if.sink    in_ch,
  pfc_out_if.source out_ch,
  pfc_cfg_if.sink   cfg
);

  logic [pfc_pkg::ByteW-1:0] start_mark;
  logic [pfc_pkg::ByteW-1:0] end_char;

  pfc_pkg::grp_t grp;
  logic          grp_valid;
  logic          grp_ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_mark <= pfc_pkg::StartMarkReset;
      end_char <= pfc_pkg::EndCharReset;
    end else if (cfg.valid && cfg.ready) begin
      case (pfc_pkg::cfg_idx_t'(cfg.index))
        pfc_pkg::CFG_START_MARK: start_mark <= cfg.data;
        pfc_pkg::CFG_END_CHAR: end_char <= cfg.data;
        default: ;
      endcase
    end
  end

  pfc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .start_mark (start_mark),
    .grp        (grp),
    .grp_valid  (grp_valid),
    .grp_ready  (grp_ready)
  );

  pfc_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .grp       (grp),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready),
    .end_char  (end_char),
    .out_ch    (out_ch)
  );

endmodule

// File: sv/pfc_ctrl.sv
module pfc_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  pfc_in_if.sink                    in_ch,
  input  logic [pfc_pkg::ByteW-1:0] start_mark,
  output pfc_pkg::grp_t             grp,
  output logic                      grp_valid,
  input  logic                      grp_ready
);

  logic                      s_valid;
  logic                      s_mode;
  logic [pfc_pkg::ByteW-1:0] s_type;
  logic [pfc_pkg::SeqW-1:0]  s_seq;
  logic [pfc_pkg::ByteW-1:0] s_len;
  logic [pfc_pkg::ByteW-1:0] s_byte;

  logic [pfc_pkg::ByteW-1:0] bytes_left;
  logic [pfc_pkg::ByteW-1:0] bytes_left_next;
  logic                      packet_open;
  logic                      packet_open_next;

  logic [pfc_pkg::ByteW-1:0] len_sat;
  logic                      drop;
  logic                      advance;

  always_comb begin
    len_sat = (s_len > pfc_pkg::MaxData) ? pfc_pkg::MaxData : s_len;
    // data with no open packet is swallowed without results
    drop = (s_mode == pfc_pkg::ModeData) && (!packet_open || bytes_left == '0);
    advance = s_valid && (drop || grp_ready);
    in_ch.ready = !s_valid || advance;
    grp_valid = s_valid && !drop;

    grp = '0;
    bytes_left_next = bytes_left;
    packet_open_next = packet_open;
    if (s_mode == pfc_pkg::ModeHeader) begin
      grp.lit[0] = start_mark;
      grp.lit[1] = len_sat + pfc_pkg::LenOverhead;
      grp.lit[2] = {2'b00, s_seq};
      grp.lit[3] = s_type;
      grp.nlit = 3'd4;
      grp.restart = 1'b1;
      grp.close_pkt = (len_sat == '0);
      bytes_left_next = len_sat;
      packet_open_next = (len_sat != '0);
    end else begin
      grp.lit[0] = s_byte;
      grp.nlit = 3'd1;
      grp.restart = 1'b0;
      grp.close_pkt = (bytes_left == 8'd1);
      bytes_left_next = bytes_left - 8'd1;
      packet_open_next = (bytes_left != 8'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s_mode <= in_ch.mode;
      s_type <= in_ch.packet_type;
      s_seq <= in_ch.seq_num;
      s_len <= in_ch.data_len;
      s_byte <= in_ch.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left <= '0;
      packet_open <= 1'b0;
    end else if (advance && !drop) begin
      bytes_left <= bytes_left_next;
      packet_open <= packet_open_next;
    end
  end

endmodule

// File: sv/pfc_emit.sv
module pfc_emit (
  input  logic                      clk,
  input  logic                      rst,
  input  pfc_pkg::grp_t             grp,
  input  logic                      grp_valid,
  output logic                      grp_ready,
  input  logic [pfc_pkg::ByteW-1:0] end_char,
  pfc_out_if.source                 out_ch
);

  logic                        busy;
  pfc_pkg::grp_t               cur;
  logic [pfc_pkg::SlotW-1:0]   idx;
  logic [pfc_pkg::CrcW-1:0]    running_crc;
  logic [pfc_pkg::CrcW-1:0]    running_crc_next;

  logic [pfc_pkg::SlotW-1:0]   close_slot;
  logic                        in_lit;
  logic                        last;
  logic                        xfer;
  logic                        load;
  logic [pfc_pkg::CrcW-1:0]    crc_base;

  always_comb begin
    in_lit = (idx < cur.nlit);
    close_slot = idx - cur.nlit;
    last = cur.close_pkt ? (idx == cur.nlit + pfc_pkg::SlotEnd) : (idx == cur.nlit - 3'd1);
    xfer = out_ch.valid && out_ch.ready;
    grp_ready = !busy || (xfer && last);
    load = grp_valid && grp_ready;

    out_ch.valid = busy;
    out_ch.end_of_packet = 1'b0;
    if (in_lit) begin
      out_ch.out_byte = cur.lit[idx[1:0]];
    end else begin
      case (close_slot)
        pfc_pkg::SlotCrcLo: out_ch.out_byte = running_crc[7:0];
        pfc_pkg::SlotCrcHi: out_ch.out_byte = running_crc[15:8];
        pfc_pkg::SlotEnd: begin
          out_ch.out_byte = end_char;
          out_ch.end_of_packet = 1'b1;
        end
        default: out_ch.out_byte = end_char;
      endcase
    end

    // the mark byte starts the crc afresh
    crc_base = (cur.restart && idx == '0) ? '0 : running_crc;
    running_crc_next = running_crc;
    if (in_lit) begin
      running_crc_next = pfc_pkg::crc_byte(crc_base, out_ch.out_byte);
    end else if (close_slot == pfc_pkg::SlotEnd) begin
      running_crc_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx <= '0;
    end else if (xfer && last) begin
      busy <= 1'b0;
    end else if (xfer) begin
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= '0;
    end else if (xfer) begin
      running_crc <= running_crc_next;
    end
  end

endmodule
